@@ hw/rtl/irpq_pkg.sv @@
// irpq_pkg: shared types, register indexes and reset values for the
// IR pulse pair qualifier. No dependencies.
package irpq_pkg;

   localparam int TIMER_BITS_DEF = 24;
   localparam int UNIT_BITS_DEF  = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESCALE    = 3'd0,
      CSR_WINDOW_LOW  = 3'd1,
      CSR_WINDOW_HIGH = 3'd2,
      CSR_NEEDED_HITS = 3'd3,
      CSR_TIMEOUT     = 3'd4
   } csr_index_type;

   localparam logic [15:0] PRESCALE_RST    = 16'd750;
   localparam logic [15:0] WINDOW_LOW_RST  = 16'd80;
   localparam logic [15:0] WINDOW_HIGH_RST = 16'd120;
   localparam logic [7:0]  NEEDED_HITS_RST = 8'd3;
   localparam logic [23:0] TIMEOUT_RST     = 24'd1500000;

   typedef struct packed {
      logic [15:0] prescale;
      logic [15:0] window_low;
      logic [15:0] window_high;
      logic [7:0]  needed_hits;
      logic [23:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        detected;
      logic [15:0] last_interval;
      logic [7:0]  hit_total;
   } result_type;

endpackage

@@ hw/rtl/irpq_csr.sv @@
// irpq_csr: configuration register file, one write word per cycle.
// Depends on irpq_pkg.
module irpq_csr
   import irpq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prescale      <= PRESCALE_RST;
         cfg_ff.window_low    <= WINDOW_LOW_RST;
         cfg_ff.window_high   <= WINDOW_HIGH_RST;
         cfg_ff.needed_hits   <= NEEDED_HITS_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESCALE:    cfg_ff.prescale      <= csr_data[15:0];
            CSR_WINDOW_LOW:  cfg_ff.window_low    <= csr_data[15:0];
            CSR_WINDOW_HIGH: cfg_ff.window_high   <= csr_data[15:0];
            CSR_NEEDED_HITS: cfg_ff.needed_hits   <= csr_data[7:0];
            CSR_TIMEOUT:     cfg_ff.timeout_ticks <= csr_data[23:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

endmodule

@@ hw/rtl/irpq_core.sv @@
// irpq_core: qualifier state (pair phase, idle timer, interval counter,
// hit count, flag) updated once per accepted word. Depends on irpq_pkg.
module irpq_core
   import irpq_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF,
   parameter int UNIT_BITS  = UNIT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic       both_seen,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int LW = ((TIMER_BITS > 24) ? TIMER_BITS : 24) + 1;
   localparam int MW = (UNIT_BITS > 16) ? UNIT_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [UNIT_BITS-1:0]  UNIT_MAX  = {UNIT_BITS{1'b1}};

   logic                  phase_ff, phase_in;
   logic [TIMER_BITS-1:0] idle_ff, idle_in;
   logic [15:0]           pcount_ff, pcount_in;
   logic [UNIT_BITS-1:0]  units_ff, units_in;
   logic [15:0]           meas_ff, meas_in;
   logic [7:0]            hits_ff, hits_in;
   logic                  flag_ff, flag_in;

   logic [LW-1:0] timeout_ext, limit_clamp, limit, idle_inc;
   logic          expire;
   logic [15:0]   pre;
   logic [16:0]   pcount_inc;
   logic [MW-1:0] units_ext;
   logic [15:0]   meas_new;
   logic          in_window;
   logic [7:0]    hits_new;

   always_comb begin
      timeout_ext = LW'(cfg.timeout_ticks);
      limit_clamp = (timeout_ext > LW'(TIMER_MAX)) ? LW'(TIMER_MAX) : timeout_ext;
      limit       = (limit_clamp == '0) ? LW'(1) : limit_clamp;
      idle_inc    = LW'(idle_ff) + LW'(1);
      expire      = (idle_inc >= limit);

      pre        = (cfg.prescale == 16'd0) ? 16'd1 : cfg.prescale;
      pcount_inc = {1'b0, pcount_ff} + 17'd1;

      units_ext = MW'(units_ff);
      meas_new  = (units_ext > MW'(16'hFFFF)) ? 16'hFFFF : units_ext[15:0];
      in_window = (meas_new > cfg.window_low) && (meas_new < cfg.window_high);
      if (!in_window)
         hits_new = 8'd0;
      else if (hits_ff != 8'hFF)
         hits_new = hits_ff + 8'd1;
      else
         hits_new = hits_ff;

      phase_in  = phase_ff;
      idle_in   = idle_ff;
      pcount_in = pcount_ff;
      units_in  = units_ff;
      meas_in   = meas_ff;
      hits_in   = hits_ff;
      flag_in   = flag_ff;

      if (accept) begin
         if (!kind) begin
            // clock tick
            if (expire) begin
               idle_in = '0;
               hits_in = 8'd0;
               flag_in = 1'b0;
            end else begin
               idle_in = idle_inc[TIMER_BITS-1:0];
            end
            if (phase_ff) begin
               if (pcount_inc >= {1'b0, pre}) begin
                  pcount_in = 16'd0;
                  if (units_ff != UNIT_MAX)
                     units_in = units_ff + UNIT_BITS'(1);
               end else begin
                  pcount_in = pcount_inc[15:0];
               end
            end
         end else begin
            // sensor event
            idle_in = '0;
            if (both_seen) begin
               if (!phase_ff) begin
                  phase_in  = 1'b1;
                  pcount_in = 16'd0;
                  units_in  = '0;
               end else begin
                  phase_in = 1'b0;
                  meas_in  = meas_new;
                  hits_in  = hits_new;
                  if (hits_new >= cfg.needed_hits)
                     flag_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         idle_ff   <= '0;
         pcount_ff <= 16'd0;
         units_ff  <= '0;
         meas_ff   <= 16'd0;
         hits_ff   <= 8'd0;
         flag_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         idle_ff   <= idle_in;
         pcount_ff <= pcount_in;
         units_ff  <= units_in;
         meas_ff   <= meas_in;
         hits_ff   <= hits_in;
         flag_ff   <= flag_in;
      end
   end

   // result reflects the state after this word's update
   assign result.detected      = flag_in;
   assign result.last_interval = meas_in;
   assign result.hit_total     = hits_in;

endmodule

@@ hw/rtl/irpq_out.sv @@
// irpq_out: result register plus one skid entry between core and receiver.
// Depends on irpq_pkg.
module irpq_out
   import irpq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       valid_ff, skid_valid_ff;
   result_type data_ff, skid_data_ff;

   assign full      = skid_valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            valid_ff      <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!valid_ff || !out_stall) begin
         data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

endmodule

@@ hw/rtl/ir_pulse_pair_qualifier.sv @@
// ir_pulse_pair_qualifier: top level, config registers, qualifier core and
// result buffer. Depends on irpq_pkg, irpq_csr, irpq_core, irpq_out.
//
// Usage:
//  - req channel: one word per clock tick (req_kind = 0) or sensor event
//    (req_kind = 1, req_both_seen set when both receivers fired). A word is
//    taken when req_valid is high and req_stall is low.
//  - rsp channel: exactly one result word per request word, in order:
//    detected flag, last measured pair interval, current hit count.
//  - csr channel: csr_valid/csr_ready write of csr_data into register
//    csr_index (0 prescale, 1 window low, 2 window high, 3 needed hits,
//    4 timeout). csr_ready is always high; write only while idle.
//  - Throughput: one word per cycle while req_stall is low, set by the core's
//    state update. The result is registered in the result or skid register.
//  - Receiver stall: the result register plus one skid entry absorb the
//    word in flight; req_stall rises only when both hold data.
//  - Reset (synchronous): clears all qualifier state and empties the
//    result buffer; registers return to their default values.
module ir_pulse_pair_qualifier
   import irpq_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF,
   parameter int UNIT_BITS  = UNIT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic                   req_both_seen,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_detected,
   output logic [15:0]            rsp_last_interval,
   output logic [7:0]             rsp_hit_total,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   result_type core_result;
   result_type rsp_data;
   logic       accept;
   logic       buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   irpq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   irpq_core #(
      .TIMER_BITS (TIMER_BITS),
      .UNIT_BITS  (UNIT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .both_seen (req_both_seen),
      .cfg       (cfg),
      .result    (core_result)
   );

   irpq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_detected      = rsp_data.detected;
   assign rsp_last_interval = rsp_data.last_interval;
   assign rsp_hit_total     = rsp_data.hit_total;

`ifndef SYNTHESIS
   // after an accepted word, a result is always valid on rsp next cycle
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word did not produce a result");

   // skid entry only fills behind a held result
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty result register");

   // skid drains only when the receiver takes a word
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> $past(rsp_valid && !rsp_stall))
      else $error("skid entry dropped without a result being taken");
`endif

endmodule

@@ bench/ir_pulse_pair_qualifier_tb.sv @@
// Self-checking bench for ir_pulse_pair_qualifier: directed cases, then random beacon
// traffic under several register settings. Depends on irpq_pkg and the RTL top level.
module ir_pulse_pair_qualifier_tb;
   import irpq_pkg::*;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   localparam int unsigned TIMER_TOP = (1 << TIMER_BITS_DEF) - 1;
   localparam int unsigned UNIT_TOP  = (1 << UNIT_BITS_DEF) - 1;

   // Watchdog bound on a full run, with room even for the longest stalls.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 100;
   localparam int PRINT_CAP    = 30;

   // DUT inputs, known from time zero
   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_kind      = 1'b0;
   logic                   req_both_seen = 1'b0;
   logic                   rsp_stall     = 1'b0;
   logic                   csr_valid     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_data      = '0;

   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_detected;
   logic [15:0] rsp_last_interval;
   logic [7:0]  rsp_hit_total;
   logic        csr_ready;

   ir_pulse_pair_qualifier u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_both_seen     (req_both_seen),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_detected      (rsp_detected),
      .rsp_last_interval (rsp_last_interval),
      .rsp_hit_total     (rsp_hit_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the register file
   logic [15:0] cfg_prescale = PRESCALE_RST;
   logic [15:0] cfg_win_lo   = WINDOW_LOW_RST;
   logic [15:0] cfg_win_hi   = WINDOW_HIGH_RST;
   logic [7:0]  cfg_needed   = NEEDED_HITS_RST;
   logic [23:0] cfg_timeout  = TIMEOUT_RST;

   // Shadow qualifier state, all zero after reset
   logic                      pair_armed = 1'b0;
   logic [TIMER_BITS_DEF-1:0] idle_count = '0;
   logic [15:0]               pre_count  = '0;
   logic [UNIT_BITS_DEF-1:0]  unit_count = '0;
   logic [15:0]               last_iv    = '0;
   logic [7:0]                hits       = '0;
   logic                      beacon     = 1'b0;

   // Expected result words, oldest first
   result_type beacon_status_q[$];
   result_type want;

   int errors      = 0;
   int words_sent  = 0;
   int cycle_count = 0;

   // Idling controls: sender gaps, receiver bursts, and one long hold-off
   bit tx_gaps    = 1'b0;
   bit rx_gaps    = 1'b0;
   int hold_left  = 0;
   int burst_left = 0;

   // Next-state and result of the qualifier for one accepted word.
   task automatic advance_qualifier(input logic kind, input logic both);
      int unsigned limit;
      int unsigned pre;
      result_type  r;
      if (kind == KIND_EVENT) begin
         // any event restarts the idle timer; only a dual-receiver one is an edge
         idle_count = '0;
         if (both) begin
            if (!pair_armed) begin
               pair_armed = 1'b1;
               pre_count  = '0;
               unit_count = '0;
            end else begin
               pair_armed = 1'b0;
               last_iv    = unit_count;
               if (last_iv > cfg_win_lo && last_iv < cfg_win_hi) begin
                  if (hits != 8'hFF) hits = hits + 8'd1;
               end else begin
                  hits = '0;
               end
               if (hits >= cfg_needed) beacon = 1'b1;
            end
         end
      end else begin
         limit = cfg_timeout;
         if (limit > TIMER_TOP) limit = TIMER_TOP;
         if (limit == 0) limit = 1;
         if (idle_count + 1 >= limit) begin
            idle_count = '0;
            hits       = '0;
            beacon     = 1'b0;
         end else begin
            idle_count = idle_count + 1'b1;
         end
         if (pair_armed) begin
            pre = (cfg_prescale == 0) ? 1 : cfg_prescale;
            if (pre_count + 1 >= pre) begin
               pre_count = '0;
               if (unit_count != UNIT_TOP) unit_count = unit_count + 1'b1;
            end else begin
               pre_count = pre_count + 1'b1;
            end
         end
      end
      r.detected      = beacon;
      r.last_interval = last_iv;
      r.hit_total     = hits;
      beacon_status_q.push_back(r);
   endtask

   // Offer one word; valid stays up after acceptance so back-to-back words
   // need only one assignment per falling edge.
   task automatic send_word(input logic kind, input logic both);
      if (tx_gaps && $urandom_range(0, 9) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_both_seen <= both;
      do @(posedge clock); while (req_stall);
      advance_qualifier(kind, both);
      words_sent++;
   endtask

   // Ticks carry a random both_seen, which the block must ignore.
   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++) send_word(KIND_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_pair(input int ticks);
      send_word(KIND_EVENT, 1'b1);
      send_ticks(ticks);
      send_word(KIND_EVENT, 1'b1);
   endtask

   // Sender goes quiet until every expected word is back, then waits for the
   // result buffer to settle.
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (beacon_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PRESCALE:    cfg_prescale = data[15:0];
         CSR_WINDOW_LOW:  cfg_win_lo   = data[15:0];
         CSR_WINDOW_HIGH: cfg_win_hi   = data[15:0];
         CSR_NEEDED_HITS: cfg_needed   = data[7:0];
         CSR_TIMEOUT:     cfg_timeout  = data[23:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Upper data bits are junk for the narrow registers and must be dropped.
   task automatic set_config(input logic [15:0] pre, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [7:0] need,
                             input logic [23:0] tmo);
      drain();
      write_csr(CSR_PRESCALE,    {8'($urandom), pre});
      write_csr(CSR_WINDOW_LOW,  {8'($urandom), lo});
      write_csr(CSR_WINDOW_HIGH, {8'($urandom), hi});
      write_csr(CSR_NEEDED_HITS, {16'($urandom), need});
      write_csr(CSR_TIMEOUT,     tmo);
   endtask

   // Reset values: idle ticks, an event without both receivers, and a short
   // pair that measures zero units with the default prescale.
   task automatic test_reset_defaults();
      send_word(KIND_TICK, 1'b1);
      send_word(KIND_TICK, 1'b0);
      send_word(KIND_EVENT, 1'b0);
      send_pair(2);
   endtask

   // Zero prescale counts every tick as a unit; zero timeout expires on every
   // tick, so the flag set by the hit clears on the following tick.
   task automatic test_zero_settings();
      set_config(16'd0, 16'd0, 16'd3, 8'd1, 24'd0);
      send_pair(2);
      send_ticks(1);
   endtask

   // Window bounds are exclusive; then zero needed_hits on an inverted window
   // sets the flag even though the pair misses.
   task automatic test_window_edges();
      set_config(16'd1, 16'd1, 16'd3, 8'd1, 24'hFFFFFF);
      send_pair(1);
      send_pair(3);
      set_config(16'd1, 16'd5, 16'd2, 8'd0, 24'hFFFFFF);
      send_pair(0);
   endtask

   // A hit sets the flag; timer expiry then clears hit count and flag while an
   // armed measurement carries on, and the long pairs that follow miss.
   task automatic test_flag_and_expiry();
      set_config(16'd1, 16'd0, 16'd3, 8'd1, 24'd3);
      send_pair(1);
      send_pair(4);
      send_word(KIND_EVENT, 1'b1);
      send_ticks(4);
      send_word(KIND_EVENT, 1'b1);
   endtask

   // A long pair at one unit per tick lands in a narrow window; a short one
   // right after misses.
   task automatic test_long_interval();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      set_config(16'd1, 16'd199, 16'd201, 8'd1, 24'hFFFFFF);
      send_pair(200);
      send_pair(2);
   endtask

   // Writes to unused indexes must leave every register alone.
   task automatic test_unused_index();
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      set_config(16'd2, 16'd1, 16'd4, 8'd2, 24'd500);
      for (int i = int'(CSR_TIMEOUT) + 1; i < (1 << CSR_INDEX_W); i++)
         write_csr(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));
      send_pair(5);
      send_pair(6);
   endtask

   // Receiver holds off long enough for the skid buffer to fill and push the
   // stall back to the sender, which keeps offering words throughout.
   task automatic test_backpressure();
      drain();
      tx_gaps   = 1'b0;
      rx_gaps   = 1'b0;
      hold_left = 40;
      for (int i = 0; i < 12; i++)
         send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      drain();
   endtask

   // One setting, then mostly well-formed pairs, near the window unless the
   // prescale exceeds 6, with some noise: lone events, stray edges and idle tick runs.
   task automatic run_phase(input int phase, input int words);
      logic [15:0] pre;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [7:0]  need;
      logic [23:0] tmo;
      int          pre_eff;
      int          lo_u;
      int          hi_u;
      int          ticks;
      int          start;
      case (phase)
         0: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 24'hFFFFFF);
         1: set_config(16'd1, 16'd0, 16'd2, 8'd1, 24'd1);
         default: begin
            pre  = 16'($urandom_range(0, 4));
            lo   = 16'($urandom_range(0, 6));
            hi   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, lo))
                                               : 16'(lo + $urandom_range(0, 5));
            need = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
            tmo  = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(0, 8))
                                               : 24'($urandom_range(40, 400));
            set_config(pre, lo, hi, need, tmo);
         end
      endcase
      pre_eff = (cfg_prescale == 0) ? 1 : int'(cfg_prescale);
      lo_u    = (cfg_win_lo > 0) ? int'(cfg_win_lo) - 1 : 0;
      hi_u    = int'(cfg_win_hi) + 1;
      if (hi_u > 24) hi_u = 24;
      if (lo_u > hi_u) lo_u = hi_u;
      start = words_sent;
      while (words_sent - start < words) begin
         case ($urandom_range(0, 9))
            0: send_word(KIND_EVENT, 1'b0);
            1: send_word(KIND_EVENT, 1'b1);
            2: send_ticks($urandom_range(1, 12));
            default: begin
               if (pre_eff > 6) ticks = $urandom_range(0, 30);
               else ticks = $urandom_range(lo_u, hi_u) * pre_eff
                            + $urandom_range(0, pre_eff - 1);
               send_word(KIND_EVENT, 1'b1);
               if ($urandom_range(0, 4) == 0) begin
                  // event with one receiver inside a pair only restarts the timer
                  send_ticks(ticks / 2);
                  send_word(KIND_EVENT, 1'b0);
                  send_ticks(ticks - ticks / 2);
               end else begin
                  send_ticks(ticks);
               end
               send_word(KIND_EVENT, 1'b1);
            end
         endcase
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 7; p++) begin
         tx_gaps = ($urandom_range(0, 3) != 0);
         rx_gaps = ($urandom_range(0, 3) != 0);
         run_phase(p, PHASE_WORDS);
      end
   endtask

   // Last stretch runs at full rate on both sides.
   task automatic test_final_flow();
      drain();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      run_phase(7, PHASE_WORDS);
   endtask

   task automatic note_mismatch(input string field, input int exp_v, input int got_v);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
   endtask

   // Receiver: long hold-off first, then any running burst, then maybe a new
   // burst of random length.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         burst_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every result word taken is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beacon_status_q.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: unexpected result word, expected none, actual %0d/%0d/%0d",
                        $time, rsp_detected, rsp_last_interval, rsp_hit_total);
         end else begin
            want = beacon_status_q.pop_front();
            if (rsp_detected !== want.detected)
               note_mismatch("detected", want.detected, rsp_detected);
            if (rsp_last_interval !== want.last_interval)
               note_mismatch("last_interval", want.last_interval, rsp_last_interval);
            if (rsp_hit_total !== want.hit_total)
               note_mismatch("hit_total", want.hit_total, rsp_hit_total);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      test_reset_defaults();
      test_zero_settings();
      test_window_edges();
      test_flag_and_expiry();
      test_long_interval();
      test_unused_index();
      test_backpressure();
      test_random_phases();
      test_final_flow();
      drain();
      repeat (8) @(posedge clock);
      if (beacon_status_q.size() != 0) begin
         errors++;
         $display("%0t: result words missing, expected %0d more, actual 0",
                  $time, beacon_status_q.size());
      end
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ ir_pulse_pair_qualifier.f @@
hw/rtl/irpq_pkg.sv
hw/rtl/irpq_csr.sv
hw/rtl/irpq_core.sv
hw/rtl/irpq_out.sv
hw/rtl/ir_pulse_pair_qualifier.sv
bench/ir_pulse_pair_qualifier_tb.sv
